FILE: hdl/cpu6502_subset_execute_macros.svh
// Assertion macros for the checker file of the 6502 subset executor.
`ifndef CPU6502_SUBSET_EXECUTE_MACROS_SVH
`define CPU6502_SUBSET_EXECUTE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define C6502_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define C6502_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/c6502_pkg.sv
// Shared types, opcodes and flag positions for the 6502 subset executor.
`timescale 1ns / 1ps

package c6502_pkg;

	// Input transaction: one instruction
	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] operand_low;
		logic [7:0] operand_high;
	} in_item_t;

	// Result transaction: register file after the instruction
	typedef struct packed {
		logic [15:0] next_pc;
		logic [1:0]  bytes_used;
		logic [7:0]  accumulator;
		logic [7:0]  index_x;
		logic [7:0]  status_flags;
		logic [7:0]  stack_pointer;
		logic        mem_write;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic [1:0]  run_status;
	} out_item_t;

	// Opcodes
	localparam logic [7:0] OPC_ADC_IMM = 8'h69;
	localparam logic [7:0] OPC_AND_IMM = 8'h29;
	localparam logic [7:0] OPC_CMP_IMM = 8'hC9;
	localparam logic [7:0] OPC_LDA_IMM = 8'hA9;
	localparam logic [7:0] OPC_BPL     = 8'h10;
	localparam logic [7:0] OPC_BMI     = 8'h30;
	localparam logic [7:0] OPC_BVC     = 8'h50;
	localparam logic [7:0] OPC_BVS     = 8'h70;
	localparam logic [7:0] OPC_BCC     = 8'h90;
	localparam logic [7:0] OPC_BCS     = 8'hB0;
	localparam logic [7:0] OPC_BNE     = 8'hD0;
	localparam logic [7:0] OPC_BEQ     = 8'hF0;
	localparam logic [7:0] OPC_CLC     = 8'h18;
	localparam logic [7:0] OPC_CLD     = 8'hD8;
	localparam logic [7:0] OPC_CLI     = 8'h58;
	localparam logic [7:0] OPC_TAX     = 8'hAA;
	localparam logic [7:0] OPC_DEX     = 8'hCA;
	localparam logic [7:0] OPC_NOP     = 8'hEA;
	localparam logic [7:0] OPC_JMP_ABS = 8'h4C;
	localparam logic [7:0] OPC_PHA     = 8'h48;
	localparam logic [7:0] OPC_EXIT    = 8'hEF;

	// Operation class produced by decode
	typedef enum logic [3:0] {
		CLS_ADC,
		CLS_AND,
		CLS_CMP,
		CLS_LDA,
		CLS_BRANCH,
		CLS_CLC,
		CLS_CLD,
		CLS_CLI,
		CLS_TAX,
		CLS_DEX,
		CLS_NOP,
		CLS_JMP,
		CLS_PHA,
		CLS_EXIT,
		CLS_ILLEGAL
	} op_class_t;

	// Flag tested by a branch
	typedef enum logic [1:0] {
		BR_N,
		BR_V,
		BR_C,
		BR_Z
	} br_flag_t;

	// Decoded instruction handed from front to back
	typedef struct packed {
		op_class_t  cls;
		br_flag_t   br_flag;
		logic       br_pol;
		logic [7:0] operand_low;
		logic [7:0] operand_high;
	} dec_item_t;

	// Queue status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Queue geometry
	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	// Flag bit positions
	localparam int FLAG_C = 0;
	localparam int FLAG_Z = 1;
	localparam int FLAG_I = 2;
	localparam int FLAG_D = 3;
	localparam int FLAG_V = 6;
	localparam int FLAG_N = 7;

	// Run status codes
	localparam logic [1:0] RUN_OK      = 2'd0;
	localparam logic [1:0] RUN_EXIT    = 2'd1;
	localparam logic [1:0] RUN_ILLEGAL = 2'd2;

	// Reset values
	localparam logic [15:0] START_RESET = 16'h0200;
	localparam logic [7:0]  SP_RESET    = 8'hFF;
	localparam logic [7:0]  FLAGS_RESET = 8'h04;
	localparam logic [7:0]  STACK_PAGE  = 8'h01;

endpackage

FILE: hdl/cpu6502_subset_execute.sv
// Top level of the 6502 subset executor: front decode, queue, execute back end.
`timescale 1ns / 1ps

// Executes one 6502 instruction per input transaction (opcode plus up to two
// operand bytes) and returns one result transaction with PC, A, X, SP, flags,
// any PHA stack write and the run status. Sustained rate is one instruction
// per clock while out_stall is low; a result passes the decode register, a
// two-entry queue and the result register. The rate is set by the execute
// stage, which reads and updates the register file in the same cycle. The
// queue lets new instructions be accepted while a result waits in the result
// register. After an exit or an illegal opcode the block reports the frozen
// registers with bytes_used 0 until reset.
// Writing cfg_data loads the program counter; write it only while idle.
module cpu6502_subset_execute (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  c6502_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output c6502_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_data
);
	import c6502_pkg::*;

	q_stat_t   q_stat;
	logic      push;
	logic      pop;
	dec_item_t push_data;
	dec_item_t pop_data;

	c6502_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	c6502_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	c6502_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.item      (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

endmodule

FILE: hdl/c6502_front.sv
// Front end: accepts instruction transactions and decodes them into classes.
`timescale 1ns / 1ps

module c6502_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  c6502_pkg::in_item_t  in_data,
	input  c6502_pkg::q_stat_t   q_stat,
	output logic                 push,
	output c6502_pkg::dec_item_t push_data
);
	import c6502_pkg::*;

	logic      valid_s1;
	dec_item_t dec_s1;
	dec_item_t dec;

	// Classify the opcode; branches carry flag select and wanted polarity
	always_comb begin
		dec.cls          = CLS_ILLEGAL;
		dec.br_flag      = br_flag_t'(in_data.opcode[7:6]);
		dec.br_pol       = in_data.opcode[5];
		dec.operand_low  = in_data.operand_low;
		dec.operand_high = in_data.operand_high;
		case (in_data.opcode)
			OPC_ADC_IMM: dec.cls = CLS_ADC;
			OPC_AND_IMM: dec.cls = CLS_AND;
			OPC_CMP_IMM: dec.cls = CLS_CMP;
			OPC_LDA_IMM: dec.cls = CLS_LDA;
			OPC_BPL, OPC_BMI, OPC_BVC, OPC_BVS,
			OPC_BCC, OPC_BCS, OPC_BNE, OPC_BEQ: dec.cls = CLS_BRANCH;
			OPC_CLC:     dec.cls = CLS_CLC;
			OPC_CLD:     dec.cls = CLS_CLD;
			OPC_CLI:     dec.cls = CLS_CLI;
			OPC_TAX:     dec.cls = CLS_TAX;
			OPC_DEX:     dec.cls = CLS_DEX;
			OPC_NOP:     dec.cls = CLS_NOP;
			OPC_JMP_ABS: dec.cls = CLS_JMP;
			OPC_PHA:     dec.cls = CLS_PHA;
			OPC_EXIT:    dec.cls = CLS_EXIT;
			default:     dec.cls = CLS_ILLEGAL;
		endcase
	end

	// Hold the decoded transaction until the queue takes it
	assign in_stall  = valid_s1 && q_stat.full;
	assign push      = valid_s1 && !q_stat.full;
	assign push_data = dec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			dec_s1 <= dec;
		end
	end

endmodule

FILE: hdl/c6502_queue.sv
// Short queue of decoded instructions between front and back.
`timescale 1ns / 1ps

module c6502_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  c6502_pkg::dec_item_t push_data,
	input  logic                 pop,
	output c6502_pkg::dec_item_t pop_data,
	output c6502_pkg::q_stat_t   q_stat
);
	import c6502_pkg::*;

	dec_item_t      slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign q_stat.full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_data     = slot_q[rd_ptr_q];

	// Advance the pointers wrapping at the depth
	function automatic logic [QAW-1:0] bump(input logic [QAW-1:0] p);
		if (p == QAW'(QDEPTH - 1)) begin
			bump = '0;
		end else begin
			bump = p + QAW'(1);
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QAW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QAW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: hdl/c6502_back.sv
// Back end: executes decoded instructions on the register file, registers results.
`timescale 1ns / 1ps

module c6502_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  c6502_pkg::q_stat_t   q_stat,
	input  c6502_pkg::dec_item_t item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output c6502_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_data
);
	import c6502_pkg::*;

	logic [15:0] pc_q;
	logic [7:0]  sp_q;
	logic [7:0]  a_q;
	logic [7:0]  x_q;
	logic [7:0]  p_q;
	logic [1:0]  halt_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [15:0] pc_n;
	logic [7:0]  sp_n;
	logic [7:0]  a_n;
	logic [7:0]  x_n;
	logic [7:0]  p_n;
	logic [1:0]  halt_n;
	logic [1:0]  len;
	logic        wr;
	logic [8:0]  sum;
	logic [7:0]  diff;
	logic        br_bit;
	logic [15:0] pc_seq;
	logic [15:0] pc_br;
	out_item_t   res;

	// Update Z and N from a result byte
	function automatic logic [7:0] set_zn(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] f;
		f         = p;
		f[FLAG_Z] = (v == 8'h00);
		f[FLAG_N] = v[7];
		set_zn    = f;
	endfunction

	// Take a new instruction whenever the output register frees up
	assign pop = !q_stat.empty && (!out_valid_q || !out_stall);

	// Branch condition flag
	always_comb begin
		case (item.br_flag)
			BR_N:    br_bit = p_q[FLAG_N];
			BR_V:    br_bit = p_q[FLAG_V];
			BR_C:    br_bit = p_q[FLAG_C];
			BR_Z:    br_bit = p_q[FLAG_Z];
			default: br_bit = p_q[FLAG_Z];
		endcase
	end

	assign sum    = {1'b0, a_q} + {1'b0, item.operand_low} + {8'h00, p_q[FLAG_C]};
	assign diff   = a_q - item.operand_low;
	assign pc_seq = pc_q + 16'd2;
	assign pc_br  = pc_seq + {{8{item.operand_low[7]}}, item.operand_low};

	// Execute one instruction against the current register file
	always_comb begin
		a_n    = a_q;
		x_n    = x_q;
		p_n    = p_q;
		sp_n   = sp_q;
		halt_n = halt_q;
		len    = 2'd0;
		wr     = 1'b0;
		pc_n   = pc_q;
		if (halt_q == RUN_OK) begin
			case (item.cls)
				CLS_ADC: begin
					a_n       = sum[7:0];
					p_n[FLAG_C] = sum[8];
					p_n[FLAG_V] = ~(a_q[7] ^ item.operand_low[7]) & (a_q[7] ^ sum[7]);
					p_n       = set_zn(p_n, sum[7:0]);
					len       = 2'd2;
				end
				CLS_AND: begin
					a_n = a_q & item.operand_low;
					p_n = set_zn(p_q, a_q & item.operand_low);
					len = 2'd2;
				end
				CLS_CMP: begin
					p_n         = set_zn(p_q, diff);
					p_n[FLAG_C] = (a_q >= item.operand_low);
					len         = 2'd2;
				end
				CLS_LDA: begin
					a_n = item.operand_low;
					p_n = set_zn(p_q, item.operand_low);
					len = 2'd2;
				end
				CLS_BRANCH: len = 2'd2;
				CLS_CLC: begin
					p_n[FLAG_C] = 1'b0;
					len         = 2'd1;
				end
				CLS_CLD: begin
					p_n[FLAG_D] = 1'b0;
					len         = 2'd1;
				end
				CLS_CLI: begin
					p_n[FLAG_I] = 1'b0;
					len         = 2'd1;
				end
				CLS_TAX: begin
					x_n = a_q;
					p_n = set_zn(p_q, a_q);
					len = 2'd1;
				end
				CLS_DEX: begin
					x_n = x_q - 8'd1;
					p_n = set_zn(p_q, x_q - 8'd1);
					len = 2'd1;
				end
				CLS_NOP: len = 2'd1;
				CLS_JMP: len = 2'd3;
				CLS_PHA: begin
					wr   = 1'b1;
					sp_n = sp_q - 8'd1;
					len  = 2'd1;
				end
				CLS_EXIT: halt_n = RUN_EXIT;
				default:  halt_n = RUN_ILLEGAL;
			endcase
			// Select the next program counter
			if (item.cls == CLS_BRANCH) begin
				pc_n = (br_bit == item.br_pol) ? pc_br : pc_seq;
			end else if (item.cls == CLS_JMP) begin
				pc_n = {item.operand_high, item.operand_low};
			end else begin
				pc_n = pc_q + {14'd0, len};
			end
		end
	end

	// Assemble the result transaction
	always_comb begin
		res.next_pc       = pc_n;
		res.bytes_used    = len;
		res.accumulator   = a_n;
		res.index_x       = x_n;
		res.status_flags  = p_n;
		res.stack_pointer = sp_n;
		res.mem_write     = wr;
		res.write_address = wr ? {STACK_PAGE, sp_q} : 16'h0000;
		res.write_data    = wr ? a_q : 8'h00;
		res.run_status    = halt_n;
	end

	// Commit architectural state; a configuration write reloads the PC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= START_RESET;
			sp_q        <= SP_RESET;
			a_q         <= 8'h00;
			x_q         <= 8'h00;
			p_q         <= FLAGS_RESET;
			halt_q      <= RUN_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pc_q        <= pc_n;
				sp_q        <= sp_n;
				a_q         <= a_n;
				x_q         <= x_n;
				p_q         <= p_n;
				halt_q      <= halt_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				pc_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: hdl/c6502_chk.sv
// Port-level checker for the 6502 subset executor and its bind.
`timescale 1ns / 1ps
`include "cpu6502_subset_execute_macros.svh"

module c6502_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input c6502_pkg::out_item_t out_data
);
	import c6502_pkg::*;

	// Hold a stalled result
	`C6502_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

	// Halt is sticky: every later result repeats the halt code
	`C6502_ASSERT_NXT(a_halt_sticky, out_valid && !out_stall && (out_data.run_status != RUN_OK), !out_valid || (out_data.run_status == $past(out_data.run_status)), "halt code changed after halt")

	// Stack write goes to page one at the old SP and carries A
	`C6502_ASSERT_IMP(a_push_addr, out_valid && out_data.mem_write, (out_data.write_address[15:8] == STACK_PAGE) && (out_data.write_address[7:0] == out_data.stack_pointer + 8'd1) && (out_data.write_data == out_data.accumulator), "bad stack write")

	// A zero-length instruction only reports a halt
	`C6502_ASSERT_IMP(a_zero_len, out_valid && (out_data.bytes_used == 2'd0), (out_data.run_status != RUN_OK) && !out_data.mem_write, "zero length while running")

endmodule

bind cpu6502_subset_execute c6502_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

FILE: tb/testbench.sv
// Self-checking testbench for the 6502 subset executor: directed table, random programs, halt.
`timescale 1ns / 1ps

module testbench;
	import c6502_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int N_DIRECTED     = 25;
	localparam int N_PHASES       = 6;
	localparam int PHASE_ITEMS    = 235;
	localparam int MAX_REPORTS    = 10;
	localparam int LONG_HOLD      = 150;
	localparam int HOLD_AFTER     = 400;

	// One row of the directed table; want is used only where typed is set
	typedef struct {
		in_item_t  instr;
		bit        typed;
		out_item_t want;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_we;
	logic [15:0] cfg_data;

	// Register file mirrored by the instruction predictor
	logic [15:0] cpu_pc;
	logic [7:0]  cpu_sp;
	logic [7:0]  cpu_a;
	logic [7:0]  cpu_x;
	logic [7:0]  cpu_p;
	logic [1:0]  cpu_halt;

	out_item_t   expected_regs[$];
	int          fail_count     = 0;
	int          results_seen   = 0;
	int          idle_cycles    = 0;
	int          stall_left     = 0;
	bit          gaps_on        = 1'b1;
	bit          long_hold_done = 1'b0;

	cpu6502_subset_execute uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Update Z and N from a result byte
	function automatic void update_zn(input logic [7:0] v);
		cpu_p[FLAG_Z] = (v == 8'h00);
		cpu_p[FLAG_N] = v[7];
	endfunction

	// Execute one instruction on the mirrored registers and return the result transaction
	function automatic out_item_t execute_instr(input in_item_t it);
		out_item_t   r;
		logic [8:0]  sum;
		logic [7:0]  res;
		logic [7:0]  lo;
		logic [1:0]  len;
		bit          is_branch;
		bit          taken;
		r = '0;
		len = 2'd0;
		is_branch = 1'b0;
		taken = 1'b0;
		lo = it.operand_low;
		if (cpu_halt == RUN_OK) begin
			case (it.opcode)
				OPC_ADC_IMM: begin
					sum = {1'b0, cpu_a} + {1'b0, lo} + {8'h00, cpu_p[FLAG_C]};
					res = sum[7:0];
					cpu_p[FLAG_C] = sum[8];
					cpu_p[FLAG_V] = ~(cpu_a[7] ^ lo[7]) & (cpu_a[7] ^ res[7]);
					cpu_a = res;
					update_zn(cpu_a);
					len = 2'd2;
				end
				OPC_AND_IMM: begin
					cpu_a = cpu_a & lo;
					update_zn(cpu_a);
					len = 2'd2;
				end
				OPC_CMP_IMM: begin
					res = cpu_a - lo;
					update_zn(res);
					cpu_p[FLAG_C] = (cpu_a >= lo);
					len = 2'd2;
				end
				OPC_LDA_IMM: begin
					cpu_a = lo;
					update_zn(cpu_a);
					len = 2'd2;
				end
				OPC_BCC: begin is_branch = 1'b1; taken = !cpu_p[FLAG_C]; end
				OPC_BCS: begin is_branch = 1'b1; taken = cpu_p[FLAG_C]; end
				OPC_BEQ: begin is_branch = 1'b1; taken = cpu_p[FLAG_Z]; end
				OPC_BNE: begin is_branch = 1'b1; taken = !cpu_p[FLAG_Z]; end
				OPC_BMI: begin is_branch = 1'b1; taken = cpu_p[FLAG_N]; end
				OPC_BPL: begin is_branch = 1'b1; taken = !cpu_p[FLAG_N]; end
				OPC_BVS: begin is_branch = 1'b1; taken = cpu_p[FLAG_V]; end
				OPC_BVC: begin is_branch = 1'b1; taken = !cpu_p[FLAG_V]; end
				OPC_CLC: begin cpu_p[FLAG_C] = 1'b0; len = 2'd1; end
				OPC_CLD: begin cpu_p[FLAG_D] = 1'b0; len = 2'd1; end
				OPC_CLI: begin cpu_p[FLAG_I] = 1'b0; len = 2'd1; end
				OPC_TAX: begin cpu_x = cpu_a; update_zn(cpu_x); len = 2'd1; end
				OPC_DEX: begin cpu_x = cpu_x - 8'd1; update_zn(cpu_x); len = 2'd1; end
				OPC_NOP: len = 2'd1;
				OPC_JMP_ABS: begin
					cpu_pc = {it.operand_high, lo};
					len = 2'd3;
				end
				OPC_PHA: begin
					r.mem_write = 1'b1;
					r.write_address = {STACK_PAGE, cpu_sp};
					r.write_data = cpu_a;
					cpu_sp = cpu_sp - 8'd1;
					len = 2'd1;
				end
				OPC_EXIT: cpu_halt = RUN_EXIT;
				default: cpu_halt = RUN_ILLEGAL;
			endcase
			// Branch target is relative to the following instruction
			if (is_branch) begin
				cpu_pc = cpu_pc + 16'd2;
				if (taken)
					cpu_pc = cpu_pc + {{8{lo[7]}}, lo};
				len = 2'd2;
			end else if (it.opcode != OPC_JMP_ABS) begin
				cpu_pc = cpu_pc + {14'd0, len};
			end
		end
		r.next_pc = cpu_pc;
		r.bytes_used = len;
		r.accumulator = cpu_a;
		r.index_x = cpu_x;
		r.status_flags = cpu_p;
		r.stack_pointer = cpu_sp;
		r.run_status = cpu_halt;
		return r;
	endfunction

	function automatic bit is_known(input logic [7:0] op);
		case (op)
			OPC_ADC_IMM, OPC_AND_IMM, OPC_CMP_IMM, OPC_LDA_IMM,
			OPC_BPL, OPC_BMI, OPC_BVC, OPC_BVS, OPC_BCC, OPC_BCS, OPC_BNE, OPC_BEQ,
			OPC_CLC, OPC_CLD, OPC_CLI, OPC_TAX, OPC_DEX, OPC_NOP,
			OPC_JMP_ABS, OPC_PHA, OPC_EXIT: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Pick any opcode that keeps the core running
	function automatic logic [7:0] pick_opcode();
		case ($urandom_range(19))
			0: return OPC_ADC_IMM;
			1: return OPC_AND_IMM;
			2: return OPC_CMP_IMM;
			3: return OPC_LDA_IMM;
			4: return OPC_BPL;
			5: return OPC_BMI;
			6: return OPC_BVC;
			7: return OPC_BVS;
			8: return OPC_BCC;
			9: return OPC_BCS;
			10: return OPC_BNE;
			11: return OPC_BEQ;
			12: return OPC_CLC;
			13: return OPC_CLD;
			14: return OPC_CLI;
			15: return OPC_TAX;
			16: return OPC_DEX;
			17: return OPC_JMP_ABS;
			18: return OPC_PHA;
			default: return OPC_NOP;
		endcase
	endfunction

	// Operand byte biased toward zero, all ones and the sign boundary
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 15) return 8'h00;
		if (r < 30) return 8'hFF;
		if (r < 38) return 8'h80;
		if (r < 45) return 8'h7F;
		return 8'($urandom);
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic string fmt_result(input out_item_t v);
		return $sformatf("pc=%h len=%0d a=%h x=%h p=%h sp=%h we=%b wa=%h wd=%h st=%0d",
			v.next_pc, v.bytes_used, v.accumulator, v.index_x, v.status_flags,
			v.stack_pointer, v.mem_write, v.write_address, v.write_data, v.run_status);
	endfunction

	// Offer one instruction, hold it until accepted, then queue its expected result
	task automatic send_instr(input in_item_t it, input bit typed, input out_item_t want);
		int        gap;
		out_item_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		predicted = execute_instr(it);
		expected_regs.insert(expected_regs.size(), typed ? want : predicted);
		@(negedge clk);
	endtask

	// Stop offering and wait until every result is back and the pipe is empty
	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (expected_regs.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Load a new start address; this also moves the program counter
	task automatic write_start(input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		cpu_pc = value;
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		string     bad;
		results_seen++;
		if (expected_regs.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("unexpected result transaction: %s", fmt_result(got));
			return;
		end
		want = expected_regs.pop_front();
		bad = "";
		if (got.next_pc !== want.next_pc) bad = {bad, " next_pc"};
		if (got.bytes_used !== want.bytes_used) bad = {bad, " bytes_used"};
		if (got.accumulator !== want.accumulator) bad = {bad, " accumulator"};
		if (got.index_x !== want.index_x) bad = {bad, " index_x"};
		if (got.status_flags !== want.status_flags) bad = {bad, " status_flags"};
		if (got.stack_pointer !== want.stack_pointer) bad = {bad, " stack_pointer"};
		if (got.mem_write !== want.mem_write) bad = {bad, " mem_write"};
		if (got.write_address !== want.write_address) bad = {bad, " write_address"};
		if (got.write_data !== want.write_data) bad = {bad, " write_data"};
		if (got.run_status !== want.run_status) bad = {bad, " run_status"};
		if (bad != "") begin
			fail_count++;
			if (fail_count <= MAX_REPORTS) begin
				$display("result %0d mismatch in%s", results_seen, bad);
				$display("  expected %s", fmt_result(want));
				$display("  actual   %s", fmt_result(got));
			end
		end
	endtask

	// Check results and watch for a hung handshake
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (out_valid && !out_stall)
				check_result(out_data);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Drive result backpressure; once, hold off long enough to fill the block
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
			long_hold_done = 1'b1;
			stall_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			stall_left = pick_gap();
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	initial begin
		step_row_t   rows [N_DIRECTED];
		logic [15:0] starts [N_PHASES];
		in_item_t    it;

		rows = '{
			'{'{OPC_LDA_IMM, 8'h00, 8'h00}, 1'b1,
				'{16'h0202, 2'd2, 8'h00, 8'h00, 8'h06, 8'hFF, 1'b0, 16'h0000, 8'h00, RUN_OK}},
			'{'{OPC_LDA_IMM, 8'hFF, 8'hFF}, 1'b1,
				'{16'h0204, 2'd2, 8'hFF, 8'h00, 8'h84, 8'hFF, 1'b0, 16'h0000, 8'h00, RUN_OK}},
			'{'{OPC_ADC_IMM, 8'h01, 8'h00}, 1'b1,
				'{16'h0206, 2'd2, 8'h00, 8'h00, 8'h07, 8'hFF, 1'b0, 16'h0000, 8'h00, RUN_OK}},
			'{'{OPC_ADC_IMM, 8'h7F, 8'h00}, 1'b1,
				'{16'h0208, 2'd2, 8'h80, 8'h00, 8'hC4, 8'hFF, 1'b0, 16'h0000, 8'h00, RUN_OK}},
			'{'{OPC_BVS, 8'h7F, 8'h00}, 1'b1,
				'{16'h0289, 2'd2, 8'h80, 8'h00, 8'hC4, 8'hFF, 1'b0, 16'h0000, 8'h00, RUN_OK}},
			'{'{OPC_BMI, 8'h80, 8'h00}, 1'b1,
				'{16'h020B, 2'd2, 8'h80, 8'h00, 8'hC4, 8'hFF, 1'b0, 16'h0000, 8'h00, RUN_OK}},
			'{'{OPC_BVC, 8'h55, 8'hAA}, 1'b0, '0},
			'{'{OPC_CLI, 8'h00, 8'h00}, 1'b0, '0},
			'{'{OPC_CLD, 8'hFF, 8'hFF}, 1'b0, '0},
			'{'{OPC_TAX, 8'h00, 8'h00}, 1'b0, '0},
			'{'{OPC_DEX, 8'h00, 8'h00}, 1'b0, '0},
			'{'{OPC_PHA, 8'h00, 8'h00}, 1'b0, '0},
			'{'{OPC_CMP_IMM, 8'h80, 8'h00}, 1'b0, '0},
			'{'{OPC_BEQ, 8'h00, 8'h00}, 1'b0, '0},
			'{'{OPC_BNE, 8'hFE, 8'h00}, 1'b0, '0},
			'{'{OPC_BCS, 8'hFE, 8'h00}, 1'b0, '0},
			'{'{OPC_CLC, 8'h00, 8'h00}, 1'b0, '0},
			'{'{OPC_BCC, 8'h80, 8'h00}, 1'b0, '0},
			'{'{OPC_AND_IMM, 8'h0F, 8'h00}, 1'b0, '0},
			'{'{OPC_BPL, 8'h7F, 8'h00}, 1'b0, '0},
			'{'{OPC_NOP, 8'h00, 8'h00}, 1'b0, '0},
			'{'{OPC_JMP_ABS, 8'hFE, 8'hFF}, 1'b0, '0},
			'{'{OPC_NOP, 8'h00, 8'h00}, 1'b0, '0},
			'{'{OPC_PHA, 8'h00, 8'h00}, 1'b0, '0},
			'{'{OPC_JMP_ABS, 8'h00, 8'h00}, 1'b0, '0}
		};
		starts = '{16'hFFFF, 16'h0000, 16'($urandom), 16'hFFFE, 16'($urandom), 16'($urandom)};

		// Hold reset and park every input at a known value
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		cpu_pc = START_RESET;
		cpu_sp = SP_RESET;
		cpu_a = 8'h00;
		cpu_x = 8'h00;
		cpu_p = FLAGS_RESET;
		cpu_halt = RUN_OK;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table from the reset start address
		for (int i = 0; i < N_DIRECTED; i++)
			send_instr(rows[i].instr, rows[i].typed, rows[i].want);

		// Random programs, each from a new start address; the second runs without gaps
		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_all_results();
			write_start(starts[ph]);
			gaps_on = (ph != 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				it.opcode = pick_opcode();
				it.operand_low = pick_byte();
				it.operand_high = pick_byte();
				send_instr(it, 1'b0, '0);
			end
		end

		// Halt for good: exit or an unknown opcode, whichever the seed picks
		gaps_on = 1'b1;
		if ($urandom_range(1))
			it.opcode = OPC_EXIT;
		else
			do it.opcode = 8'($urandom); while (is_known(it.opcode));
		it.operand_low = pick_byte();
		it.operand_high = pick_byte();
		send_instr(it, 1'b0, '0);

		// A halted core ignores every instruction, legal opcodes included
		for (int n = 0; n < 6; n++) begin
			it.opcode = (n % 2) ? pick_opcode() : 8'($urandom);
			it.operand_low = pick_byte();
			it.operand_high = pick_byte();
			send_instr(it, 1'b0, '0);
		end
		wait_all_results();
		write_start(16'($urandom));
		for (int n = 0; n < 4; n++) begin
			it.opcode = pick_opcode();
			it.operand_low = pick_byte();
			it.operand_high = pick_byte();
			send_instr(it, 1'b0, '0);
		end

		// Drain, then give stray results a chance to show up
		wait_all_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: cpu6502_subset_execute.f
+incdir+hdl
hdl/c6502_pkg.sv
hdl/c6502_front.sv
hdl/c6502_queue.sv
hdl/c6502_back.sv
hdl/cpu6502_subset_execute.sv
hdl/c6502_chk.sv
tb/testbench.sv
